@@ hw/rtl/tmp_pkg.sv @@
// Shared types and constants for the trapezoid motion profile block.
// Used by tmp_ctrl, tmp_dp and trapezoid_motion_profile.
package tmp_pkg;

   localparam int DIV_STEPS  = 64;
   localparam int SQRT_STEPS = 32;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   localparam logic [1:0] REG_MAX_VELOCITY     = 2'd0;
   localparam logic [1:0] REG_MAX_ACCELERATION = 2'd1;
   localparam logic [1:0] REG_TICK_PERIOD      = 2'd2;

   localparam logic [30:0] MAX_VELOCITY_RST     = 31'd65536;
   localparam logic [30:0] MAX_ACCELERATION_RST = 31'd65536;
   localparam logic [16:0] TICK_PERIOD_RST      = 17'd328;

   localparam logic [32:0] TOL_LSB = 33'd66;

   localparam logic CMD_SET_GOAL = 1'b0;
   localparam logic CMD_TICK     = 1'b1;

   typedef struct packed {
      logic        command;
      logic [31:0] goal_position;
      logic [31:0] start_position;
   } req_item_type;

   typedef struct packed {
      logic [31:0] ref_position;
      logic [31:0] ref_velocity;
      logic [31:0] ref_acceleration;
      logic        at_goal;
   } rsp_item_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_MUL_VV,
      OP_COMPARE,
      OP_DIV_TRI,
      OP_DIV_ACC,
      OP_DIV_STEP,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_PEAK,
      OP_TRI_DONE,
      OP_ACC_DONE,
      OP_CRU_DONE,
      OP_TICK_MUL,
      OP_TICK_VEL,
      OP_TICK_STEP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      pos_update;
      logic      result;
   } dp_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic is_tri;
   } dp_status_type;

endpackage

@@ hw/rtl/trapezoid_motion_profile.sv @@
// Top level of the trapezoid motion profile generator.
// Instantiates tmp_ctrl and tmp_dp; uses tmp_pkg.
//
// Usage: req_valid/req_stall carries one item: command 0 plans a new move
// from start_position to goal_position, command 1 advances time one tick.
// Every item gives exactly one item on rsp_valid/rsp_stall with the
// reference position, velocity, acceleration and at_goal flag (Q16.16).
// csr_valid/csr_ready writes max_velocity (0), max_acceleration (1) and
// tick_period (2); csr_ready is always high. Write only while idle.
// A set-goal item runs the one-bit-per-cycle divider (64 steps per
// division) once and then the two-bit-per-cycle square root (32 steps)
// for a triangular profile, or the divider twice for a trapezoidal one.
// One item is in work at a time; the next is accepted in the cycle after
// the previous result is loaded, even while that result is still stalled.
// A stalled result holds; a finished item waits for the result register.
// Reset (synchronous) clears the position, target and phase-time state and loads register defaults.
module trapezoid_motion_profile import tmp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   tmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tmp_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_item  (rsp_item)
   );

endmodule

@@ hw/rtl/tmp_dp.sv @@
// Datapath: config registers, profile state, shared multiplier,
// bit-serial divider and square root, result register. Uses tmp_pkg.
module tmp_dp import tmp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_wdata,
   input  req_item_type  req_item,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output rsp_item_type  rsp_item
);

   logic [30:0] vel_cfg_ff, acc_cfg_ff;
   logic [16:0] tick_cfg_ff;
   logic [30:0] vel_eff, acc_eff;

   logic        cmd_ff, tri_ff, dirneg_ff;
   logic [31:0] mag_ff, target_ff, pos_ff;
   logic [31:0] elapsed_ff, prev_ff, aend_ff, cend_ff, total_ff;
   logic [30:0] peak_ff, vel_ff;
   logic [63:0] prod_ff, quo_ff;
   logic [30:0] rem_ff;
   logic [33:0] srem_ff;
   logic [31:0] root_ff;
   logic [30:0] div_ff;
   rsp_item_type rsp_ff;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [32:0] goal33, start33, goal_diff;
   logic [32:0] tsum;
   logic [31:0] tsat;
   logic        ph_acc, ph_cru, ph_dec, running;
   logic [31:0] quo_sat;
   logic [31:0] dsh;
   logic [35:0] ssh;
   logic [33:0] strial;
   logic [32:0] cend_tot;
   logic [32:0] cend_sum;
   logic [47:0] prod_hi;
   logic [47:0] vraw;
   logic [31:0] dt;
   logic [49:0] pos50, step50, pos_sum;
   logic [31:0] pos_sat, pos_in;
   logic [32:0] gdiff, gabs;
   logic        at_goal;
   logic [31:0] vel_out, acc_mag, acc_out;

   assign vel_eff = (vel_cfg_ff == '0) ? 31'd1 : vel_cfg_ff;
   assign acc_eff = (acc_cfg_ff == '0) ? 31'd1 : acc_cfg_ff;

   assign goal33    = {req_item.goal_position[31], req_item.goal_position};
   assign start33   = {req_item.start_position[31], req_item.start_position};
   assign goal_diff = goal33 - start33;

   assign tsum = {1'b0, elapsed_ff} + {16'd0, tick_cfg_ff};
   assign tsat = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];

   assign ph_acc  = elapsed_ff < aend_ff;
   assign ph_cru  = !ph_acc && (elapsed_ff < cend_ff);
   assign running = elapsed_ff < total_ff;
   assign ph_dec  = !ph_acc && !ph_cru && running;

   always_comb begin
      mul_a = {1'b0, acc_eff};
      mul_b = root_ff;
      case (cmd.op)
         OP_MUL_VV:   begin mul_a = {1'b0, vel_eff}; mul_b = {1'b0, vel_eff}; end
         OP_COMPARE:  mul_b = mag_ff;
         OP_TICK_MUL: mul_b = ph_acc ? elapsed_ff : (elapsed_ff - cend_ff);
         OP_TICK_STEP: begin mul_a = {1'b0, vel_ff}; mul_b = dt; end
         default:     mul_b = root_ff;
      endcase
   end
   assign mul_p = mul_a * mul_b;

   assign quo_sat  = (quo_ff[63:32] != '0) ? 32'hFFFF_FFFF : quo_ff[31:0];
   assign dsh      = {rem_ff, quo_ff[63]};
   assign ssh      = {srem_ff, quo_ff[63:62]};
   assign strial   = {root_ff, 2'b01};
   assign cend_sum = {1'b0, quo_sat} + {1'b0, aend_ff};
   assign cend_tot = {root_ff, 1'b0};
   assign prod_hi  = prod_ff[63:16];

   always_comb begin
      vraw = '0;
      if (ph_acc) begin
         vraw = prod_hi;
      end else if (ph_cru) begin
         vraw = {17'd0, peak_ff};
      end else if (ph_dec) begin
         vraw = (prod_hi > {17'd0, peak_ff}) ? 48'd0 : ({17'd0, peak_ff} - prod_hi);
      end
   end

   assign dt = (elapsed_ff >= prev_ff) ? (elapsed_ff - prev_ff) : 32'd0;

   assign pos50   = {{18{pos_ff[31]}}, pos_ff};
   assign step50  = {2'b00, prod_hi};
   assign pos_sum = dirneg_ff ? (pos50 - step50) : (pos50 + step50);
   always_comb begin
      if (pos_sum[49:31] == '0 || pos_sum[49:31] == '1) begin
         pos_sat = pos_sum[31:0];
      end else begin
         pos_sat = pos_sum[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
   end
   assign pos_in = running ? pos_sat : pos_ff;

   assign gdiff   = {target_ff[31], target_ff} - {pos_ff[31], pos_ff};
   assign gabs    = gdiff[32] ? (33'd0 - gdiff) : gdiff;
   assign at_goal = !running || (gabs < TOL_LSB);

   always_comb begin
      vel_out = '0;
      acc_mag = '0;
      if (cmd_ff == CMD_TICK) begin
         vel_out = {1'b0, vel_ff};
         acc_mag = (ph_acc || ph_dec) ? {1'b0, acc_eff} : 32'd0;
      end
      acc_out = (ph_dec && cmd_ff == CMD_TICK) ? (32'd0 - acc_mag) : acc_mag;
      if (dirneg_ff) begin
         vel_out = 32'd0 - vel_out;
         acc_out = 32'd0 - acc_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_cfg_ff  <= MAX_VELOCITY_RST;
         acc_cfg_ff  <= MAX_ACCELERATION_RST;
         tick_cfg_ff <= TICK_PERIOD_RST;
         target_ff   <= '0;
         dirneg_ff   <= 1'b0;
         pos_ff      <= '0;
         elapsed_ff  <= '0;
         prev_ff     <= '0;
         aend_ff     <= '0;
         cend_ff     <= '0;
         total_ff    <= '0;
         peak_ff     <= '0;
         cmd_ff      <= CMD_SET_GOAL;
         tri_ff      <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_MAX_VELOCITY:     vel_cfg_ff  <= csr_wdata[30:0];
               REG_MAX_ACCELERATION: acc_cfg_ff  <= csr_wdata[30:0];
               REG_TICK_PERIOD:      tick_cfg_ff <= csr_wdata[16:0];
               default:              ;
            endcase
         end
         case (cmd.op)
            OP_LOAD: begin
               cmd_ff <= req_item.command;
               if (req_item.command == CMD_TICK) begin
                  elapsed_ff <= tsat;
               end else begin
                  dirneg_ff  <= goal_diff[32];
                  mag_ff     <= goal_diff[32] ? 32'(33'd0 - goal_diff) : goal_diff[31:0];
                  target_ff  <= req_item.goal_position;
                  pos_ff     <= req_item.start_position;
                  elapsed_ff <= '0;
                  prev_ff    <= '0;
               end
            end
            OP_MUL_VV:  prod_ff <= mul_p;
            OP_COMPARE: tri_ff  <= prod_ff > mul_p;
            OP_DIV_TRI: begin
               quo_ff <= {mag_ff, 32'd0};
               rem_ff <= '0;
               div_ff <= acc_eff;
            end
            OP_DIV_ACC: begin
               quo_ff <= {17'd0, vel_eff, 16'd0};
               rem_ff <= '0;
               div_ff <= acc_eff;
            end
            OP_DIV_STEP: begin
               if (dsh >= {1'b0, div_ff}) begin
                  rem_ff <= 31'(dsh - {1'b0, div_ff});
                  quo_ff <= {quo_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= dsh[30:0];
                  quo_ff <= {quo_ff[62:0], 1'b0};
               end
            end
            OP_SQRT_INIT: begin
               srem_ff <= '0;
               root_ff <= '0;
            end
            OP_SQRT_STEP: begin
               quo_ff <= {quo_ff[61:0], 2'b00};
               if (ssh >= {2'b00, strial}) begin
                  srem_ff <= 34'(ssh - {2'b00, strial});
                  root_ff <= {root_ff[30:0], 1'b1};
               end else begin
                  srem_ff <= ssh[33:0];
                  root_ff <= {root_ff[30:0], 1'b0};
               end
            end
            OP_PEAK: prod_ff <= mul_p;
            OP_TRI_DONE: begin
               aend_ff  <= root_ff;
               cend_ff  <= root_ff;
               total_ff <= cend_tot[32] ? 32'hFFFF_FFFF : cend_tot[31:0];
               peak_ff  <= (prod_ff[63:47] != '0) ? 31'h7FFF_FFFF : prod_ff[46:16];
            end
            OP_ACC_DONE: begin
               aend_ff <= quo_sat;
               quo_ff  <= {16'd0, mag_ff, 16'd0};
               rem_ff  <= '0;
               div_ff  <= vel_eff;
            end
            OP_CRU_DONE: begin
               cend_ff  <= quo_sat;
               total_ff <= cend_sum[32] ? 32'hFFFF_FFFF : cend_sum[31:0];
               peak_ff  <= vel_eff;
            end
            OP_TICK_MUL: prod_ff <= mul_p;
            OP_TICK_VEL: vel_ff  <= (vraw[47:31] != '0) ? 31'h7FFF_FFFF : vraw[30:0];
            OP_TICK_STEP: prod_ff <= mul_p;
            default: ;
         endcase
         if (cmd.pos_update) begin
            pos_ff <= pos_in;
            if (running) begin
               prev_ff <= elapsed_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result) begin
         rsp_ff.ref_position     <= pos_ff;
         rsp_ff.ref_velocity     <= vel_out;
         rsp_ff.ref_acceleration <= acc_out;
         rsp_ff.at_goal          <= at_goal;
      end
   end

   assign rsp_item       = rsp_ff;
   assign status.is_tick = cmd_ff;
   assign status.is_tri  = tri_ff;

endmodule

@@ hw/rtl/tmp_ctrl.sv @@
// Controller: sequences the datapath for set-goal and tick items and
// owns the handshakes. Uses tmp_pkg.
module tmp_ctrl import tmp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_MUL_VV, S_COMPARE, S_BRANCH,
      S_DIV_TRI, S_SQRT_INIT, S_SQRT, S_PEAK, S_TRI_DONE,
      S_DIV_ACC, S_ACC_DONE, S_DIV_CRU, S_CRU_DONE,
      S_TICK_MUL, S_TICK_VEL, S_TICK_STEP, S_TICK_POS, S_RESULT
   } state_type;

   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      cmd.op         = OP_IDLE;
      cmd.pos_update = 1'b0;
      cmd.result     = 1'b0;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.op   = OP_LOAD;
            state_in = S_DECODE;
         end
         S_DECODE:  state_in = status.is_tick ? S_TICK_MUL : S_MUL_VV;
         S_MUL_VV:  begin cmd.op = OP_MUL_VV;  state_in = S_COMPARE; end
         S_COMPARE: begin cmd.op = OP_COMPARE; state_in = S_BRANCH; end
         S_BRANCH: begin
            cnt_in = '0;
            if (status.is_tri) begin
               cmd.op = OP_DIV_TRI;  state_in = S_DIV_TRI;
            end else begin
               cmd.op = OP_DIV_ACC;  state_in = S_DIV_ACC;
            end
         end
         S_DIV_TRI: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_SQRT_INIT;
         end
         S_SQRT_INIT: begin
            cmd.op = OP_SQRT_INIT; cnt_in = '0; state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = OP_SQRT_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) state_in = S_PEAK;
         end
         S_PEAK:     begin cmd.op = OP_PEAK;     state_in = S_TRI_DONE; end
         S_TRI_DONE: begin cmd.op = OP_TRI_DONE; state_in = S_RESULT; end
         S_DIV_ACC: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_ACC_DONE;
         end
         S_ACC_DONE: begin
            cmd.op = OP_ACC_DONE; cnt_in = '0; state_in = S_DIV_CRU;
         end
         S_DIV_CRU: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_CRU_DONE;
         end
         S_CRU_DONE:  begin cmd.op = OP_CRU_DONE;  state_in = S_RESULT; end
         S_TICK_MUL:  begin cmd.op = OP_TICK_MUL;  state_in = S_TICK_VEL; end
         S_TICK_VEL:  begin cmd.op = OP_TICK_VEL;  state_in = S_TICK_STEP; end
         S_TICK_STEP: begin cmd.op = OP_TICK_STEP; state_in = S_TICK_POS; end
         S_TICK_POS:  begin cmd.pos_update = 1'b1; state_in = S_RESULT; end
         S_RESULT: if (out_free) begin
            cmd.result = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.result ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.result))
      else $error("result shown without a result load");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.result |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while held");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LOAD) |=> (state_ff == S_DECODE))
      else $error("load not followed by decode");

endmodule

@@ dv/trapezoid_motion_profile_tb.sv @@
// Self-checking testbench for trapezoid_motion_profile: drives set-goal and tick items,
// predicts every result with a Q16.16 profile model and compares field by field.
// Depends on tmp_pkg and the trapezoid_motion_profile RTL.
module trapezoid_motion_profile_tb;
   import tmp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = REG_MAX_VELOCITY;
   logic [31:0] csr_wdata = '0;

   trapezoid_motion_profile u_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // profile model state
   logic [63:0] m_vmax, m_amax, m_tick;
   logic signed [63:0] m_target, m_pos;
   logic m_neg;
   logic [63:0] m_elapsed, m_prev, m_acc_end, m_cru_end, m_total, m_peak;

   req_item_type pending_items[$];
   rsp_item_type expected_rsp[$];
   int errors = 0;
   int idle_cycles = 0;
   bit stim_done = 0;
   int hold_off = 0;
   bit pressure_req = 0;

   function automatic logic [63:0] sat32u(logic [63:0] x);
      return x > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : x;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r, b;
      r = '0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic model_reset();
      m_vmax = 64'd65536; m_amax = 64'd65536; m_tick = 64'd328;
      m_target = '0; m_pos = '0; m_neg = 1'b0;
      m_elapsed = '0; m_prev = '0; m_acc_end = '0; m_cru_end = '0; m_total = '0;
      m_peak = '0;
   endtask

   task automatic predict_profile(req_item_type it);
      logic [63:0] vel, acc, v, a, mag, t, drop, dt;
      logic signed [63:0] goal, start, delta, sv, sa, step, np, diff;
      logic at_g, dec;
      rsp_item_type r;
      vel = m_vmax != 0 ? m_vmax : 64'd1;
      acc = m_amax != 0 ? m_amax : 64'd1;
      v = '0; a = '0;
      if (it.command == CMD_SET_GOAL) begin
         goal = 64'($signed(it.goal_position));
         start = 64'($signed(it.start_position));
         delta = goal - start;
         m_neg = delta < 0;
         mag = delta < 0 ? -delta : delta;
         if (vel * vel > mag * acc) begin
            t = sat32u(int_sqrt((mag << 32) / acc));
            m_acc_end = t; m_cru_end = t;
            m_total = sat32u(2 * t);
            m_peak = (acc * t) >> 16;
            if (m_peak > 64'h7FFF_FFFF) m_peak = 64'h7FFF_FFFF;
         end else begin
            m_acc_end = sat32u((vel << 16) / acc);
            m_cru_end = sat32u((mag << 16) / vel);
            m_total = sat32u(m_cru_end + m_acc_end);
            m_peak = vel;
         end
         m_target = goal; m_pos = start; m_elapsed = '0; m_prev = '0;
      end else begin
         t = sat32u(m_elapsed + m_tick);
         m_elapsed = t;
         if (t < m_acc_end) begin
            a = acc; v = (acc * t) >> 16;
         end else if (t < m_cru_end) begin
            v = m_peak;
         end else if (t < m_total) begin
            drop = (acc * (t - m_cru_end)) >> 16;
            a = acc;
            v = drop > m_peak ? 64'd0 : m_peak - drop;
         end
         if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
         if (t < m_total) begin
            dt = t >= m_prev ? t - m_prev : 64'd0;
            step = $signed((v * dt) >> 16);
            np = m_neg ? m_pos - step : m_pos + step;
            if (np > 64'sd2147483647) np = 64'sd2147483647;
            if (np < -64'sd2147483648) np = -64'sd2147483648;
            m_pos = np;
            m_prev = t;
         end
      end
      diff = m_target - m_pos;
      if (diff < 0) diff = -diff;
      at_g = m_elapsed >= m_total || diff < $signed({31'd0, TOL_LSB});
      sv = $signed(v); sa = $signed(a);
      dec = it.command == CMD_TICK && m_elapsed >= m_cru_end && m_elapsed < m_total
            && m_elapsed >= m_acc_end;
      if (dec) sa = -sa;
      if (m_neg) begin
         sv = -sv; sa = -sa;
      end
      r.ref_position = m_pos[31:0];
      r.ref_velocity = sv[31:0];
      r.ref_acceleration = sa[31:0];
      r.at_goal = at_g;
      expected_rsp.push_back(r);
   endtask

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_profile(req_item);
            void'(pending_items.pop_front());
            send_gap = pressure_req ? 0 : $urandom_range(0, 19);
            if (send_gap > 0 || pending_items.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               req_item <= pending_items[0];
            end
         end else if (!req_valid) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
            end else if (pending_items.size() > 0) begin
               req_valid <= 1'b1;
               req_item <= pending_items[0];
            end
         end
      end
   end

   // monitor and receiver stall
   int recv_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("result with nothing expected");
               errors++;
            end else begin
               rsp_item_type e;
               e = expected_rsp.pop_front();
               if (rsp_item.ref_position !== e.ref_position) begin
                  $error("ref_position exp %h got %h", e.ref_position, rsp_item.ref_position);
                  errors++;
               end
               if (rsp_item.ref_velocity !== e.ref_velocity) begin
                  $error("ref_velocity exp %h got %h", e.ref_velocity, rsp_item.ref_velocity);
                  errors++;
               end
               if (rsp_item.ref_acceleration !== e.ref_acceleration) begin
                  $error("ref_acceleration exp %h got %h", e.ref_acceleration,
                         rsp_item.ref_acceleration);
                  errors++;
               end
               if (rsp_item.at_goal !== e.at_goal) begin
                  $error("at_goal exp %b got %b", e.at_goal, rsp_item.at_goal);
                  errors++;
               end
            end
            recv_gap = $urandom_range(0, 19);
            if ($urandom_range(0, 2) == 0) recv_gap = 0;
         end
         if (hold_off > 0) begin
            hold_off = hold_off - 1;
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("trapezoid_motion_profile regression: fail");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_MAX_VELOCITY) m_vmax = 64'(val & 32'h7FFF_FFFF);
      else if (idx == REG_MAX_ACCELERATION) m_amax = 64'(val & 32'h7FFF_FFFF);
      else if (idx == REG_TICK_PERIOD) m_tick = 64'(val & 32'h1_FFFF);
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || expected_rsp.size() > 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   function automatic req_item_type goal_item(logic [31:0] g, logic [31:0] s);
      req_item_type it;
      it.command = CMD_SET_GOAL;
      it.goal_position = g;
      it.start_position = s;
      return it;
   endfunction

   function automatic req_item_type tick_item();
      req_item_type it;
      it.command = CMD_TICK;
      it.goal_position = $urandom;
      it.start_position = $urandom;
      return it;
   endfunction

   task automatic random_moves(int n_items, int dist_bits);
      int k;
      logic [31:0] s, d;
      k = 0;
      while (k < n_items) begin
         s = $urandom;
         d = 32'($urandom & ((64'd1 << dist_bits) - 1));
         if ($urandom_range(0, 9) == 0) begin
            pending_items.push_back(goal_item($urandom, $urandom));
         end else begin
            pending_items.push_back(goal_item($urandom_range(0, 1) ? s + d : s - d, s));
         end
         k++;
         repeat ($urandom_range(3, 40)) begin
            pending_items.push_back(tick_item());
            k++;
         end
      end
   endtask

   initial begin
      model_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero distance, triangle and trapezoid, long times
      pending_items.push_back(tick_item());
      pending_items.push_back(goal_item(32'h0001_0000, 32'h0));
      repeat (4) pending_items.push_back(tick_item());
      pending_items.push_back(goal_item(32'h1234_0000, 32'h1234_0000));
      pending_items.push_back(tick_item());
      pending_items.push_back(goal_item(32'h7FFF_FFFF, 32'h8000_0000));
      repeat (3) pending_items.push_back(tick_item());
      pending_items.push_back(goal_item(32'h8000_0000, 32'h7FFF_FFFF));
      repeat (3) pending_items.push_back(tick_item());
      pending_items.push_back(goal_item(32'h0000_0020, 32'h0));
      repeat (2) pending_items.push_back(tick_item());
      drain();

      write_reg(REG_MAX_VELOCITY, 32'h0);
      write_reg(REG_MAX_ACCELERATION, 32'h0);
      write_reg(REG_TICK_PERIOD, 32'h1_0000);
      pending_items.push_back(goal_item(32'h0000_0100, 32'h0));
      repeat (3) pending_items.push_back(tick_item());
      pending_items.push_back(goal_item(32'hFFFF_FFFF, 32'h0));
      repeat (3) pending_items.push_back(tick_item());
      drain();

      write_reg(REG_MAX_VELOCITY, 32'hFFFF_FFFF);
      write_reg(REG_MAX_ACCELERATION, 32'h7FFF_FFFF);
      write_reg(REG_TICK_PERIOD, 32'h1);
      pending_items.push_back(goal_item(32'h7FFF_FFFF, 32'h8000_0000));
      repeat (3) pending_items.push_back(tick_item());
      drain();

      // random phases over several register settings
      repeat (5) begin
         write_reg(REG_MAX_VELOCITY, $urandom_range(0, 3) == 0 ? $urandom
                   : $urandom_range(1, 32'h0008_0000));
         write_reg(REG_MAX_ACCELERATION, $urandom_range(0, 3) == 0 ? $urandom
                   : $urandom_range(1, 32'h0008_0000));
         write_reg(REG_TICK_PERIOD, $urandom_range(0, 3) == 0 ? $urandom
                   : $urandom_range(1, 32'h0000_4000));
         random_moves(190, $urandom_range(8, 24));
         if (hold_off == 0 && !pressure_req) begin
            // long receiver hold-off while the sender keeps offering
            while (pending_items.size() > 120) @(posedge clock);
            pressure_req = 1;
            hold_off = 800;
            while (hold_off > 0) @(posedge clock);
            pressure_req = 0;
         end
         drain();
      end
      write_reg(REG_MAX_VELOCITY, 32'h1_0000);
      write_reg(REG_MAX_ACCELERATION, 32'h1_0000);
      write_reg(REG_TICK_PERIOD, 32'd328);
      random_moves(40, 20);
      drain();

      if (errors == 0) begin
         $display("trapezoid_motion_profile regression: pass");
      end else begin
         $display("trapezoid_motion_profile regression: fail");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
hw/rtl/tmp_pkg.sv
hw/rtl/tmp_dp.sv
hw/rtl/tmp_ctrl.sv
hw/rtl/trapezoid_motion_profile.sv
dv/trapezoid_motion_profile_tb.sv
